// ===== sv/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define DLF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that a condition implies another on the next clock edge, outside reset.
`define DLF_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) pre |=> post) else $error(msg);

`endif

// ===== sv/dlf_pkg.sv =====
package dlf_pkg;

  localparam int NumLanes = 8;   // centre samples rebuilt per line
  localparam int NumTaps  = 7;   // window length of the low-pass
  localparam int ExtLen   = 14;  // padded line: three pads, eight centre, three pads
  localparam int HalfLen  = 4;   // samples per variance half

  typedef logic [7:0] pix_t;

  // Stage-one record: partial variance terms, gate inputs and lane results
  typedef struct packed {
    logic signed [9:0]  sum_l;
    logic signed [9:0]  sum_r;
    logic [16:0]        sq_l;
    logic [16:0]        sq_r;
    logic [15:0]        qq;
    logic               edge_busy;
    pix_t [NumLanes-1:0] filt;
    pix_t [NumLanes-1:0] raw;
  } stage_t;

  // Merged result of one line
  typedef struct packed {
    pix_t [NumLanes-1:0] filt;
    logic [17:0]         var_sum;
    logic                smoothed;
  } result_t;

endpackage

// ===== sv/dlf_var_lane.sv =====
module dlf_var_lane
  import dlf_pkg::*;
(
  input  pix_t [HalfLen-1:0] pix_i,
  output logic signed [9:0]  sum_o,
  output logic [16:0]        sq_o
);

  logic signed [7:0]  ctr [HalfLen];
  logic signed [15:0] prod [HalfLen];

  // Center on 128 by flipping the top bit, then square each sample
  always_comb begin
    for (int k = 0; k < HalfLen; k++) begin
      ctr[k]  = signed'(pix_i[k] ^ 8'h80);
      prod[k] = ctr[k] * ctr[k];
    end
  end

  // Accumulate the centered sum and the sum of squares
  always_comb begin
    sum_o = '0;
    sq_o  = '0;
    for (int k = 0; k < HalfLen; k++) begin
      sum_o = sum_o + 10'(ctr[k]);
      sq_o  = sq_o + 17'(prod[k][14:0]);
    end
  end

endmodule

// ===== sv/dlf_filter_lane.sv =====
module dlf_filter_lane
  import dlf_pkg::*;
(
  input  pix_t [NumTaps-1:0] taps_i,
  output pix_t               pix_o
);

  logic [10:0]        sum7;
  logic [10:0]        centre_sum;
  logic [11:0]        dbl;
  logic signed [13:0] acc;
  logic [8:0]         shr;

  // Sum the seven-sample window
  always_comb begin
    sum7 = '0;
    for (int k = 0; k < NumTaps; k++) begin
      sum7 = sum7 + 11'(taps_i[k]);
    end
  end

  // Weight the centre twice, add rounding, then the prev minus next slope
  always_comb begin
    centre_sum = sum7 + 11'd4 + 11'(taps_i[3]);
    dbl        = {centre_sum, 1'b0};
    acc        = $signed({2'b00, dbl}) + $signed({6'b0, taps_i[2]})
                 - $signed({6'b0, taps_i[4]});
    shr        = acc[12:4];
  end

  // Clamp to the pixel range
  always_comb begin
    if (acc[13]) begin
      pix_o = '0;
    end else if (shr[8]) begin
      pix_o = 8'hFF;
    end else begin
      pix_o = shr[7:0];
    end
  end

endmodule

// ===== sv/dlf_merge.sv =====
module dlf_merge
  import dlf_pkg::*;
(
  input  stage_t  st_i,
  output result_t res_o
);

  logic signed [19:0] sqr_l;
  logic signed [19:0] sqr_r;
  logic [16:0]        var_l;
  logic [16:0]        var_r;
  logic [17:0]        lim_x3;
  logic [12:0]        limit;
  logic               busy;

  // Finish each half variance: sum of squares minus a quarter of the squared sum
  always_comb begin
    sqr_l = st_i.sum_l * st_i.sum_l;
    sqr_r = st_i.sum_r * st_i.sum_r;
    var_l = st_i.sq_l - sqr_l[18:2];
    var_r = st_i.sq_r - sqr_r[18:2];
  end

  // Gate limit is three q squared over 32
  always_comb begin
    lim_x3 = {2'b00, st_i.qq} + {1'b0, st_i.qq, 1'b0};
    limit  = lim_x3[17:5];
    busy   = (var_l >= {4'b0, limit}) || (var_r >= {4'b0, limit}) || st_i.edge_busy;
  end

  // Pick the low-pass result only when the line is calm
  always_comb begin
    res_o.var_sum  = {1'b0, var_l} + {1'b0, var_r};
    res_o.smoothed = !busy;
    res_o.filt     = busy ? st_i.raw : st_i.filt;
  end

endmodule

// ===== sv/deblock_line_filter_top.sv =====
// Channel        Dir  Handshake                       Payload
// s_axis (line)  in   s_axis_tvalid / s_axis_tready   tdata: sample_0..9, quant_step
// m_axis (res)   out  m_axis_tvalid / m_axis_tready   tdata: filtered_0..7, variance_sum
//                                                     tuser: smoothed
//
// One line per cycle unless m_axis_tready stalls; registered in st1_q, then out_q.
// Stage one runs the eight filter lanes and the squares of both variance halves;
// stage two squares the half sums, forms the gate and merges the lanes.
// Reset clears only the two stage valid flags.
// A stalled result holds in out_q; stage one still takes a request while it is empty.
module deblock_line_filter_top
  import dlf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // sample_0..sample_9 [79:0], quant_step [87:80]
  input  logic [87:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // filtered_0..filtered_7 [63:0], variance_sum [81:64], zero pad [87:82]
  output logic [87:0] m_axis_tdata,
  // smoothed [0]
  output logic        m_axis_tuser
);

  pix_t                smp [10];
  pix_t                q;
  pix_t                pad_l;
  pix_t                pad_r;
  pix_t                ext [ExtLen];
  pix_t [NumTaps-1:0]  lane_taps [NumLanes];
  pix_t [NumLanes-1:0] lane_pix;
  logic signed [9:0]   sum_l;
  logic signed [9:0]   sum_r;
  logic [16:0]         sq_l;
  logic [16:0]         sq_r;
  stage_t              st1_d;
  stage_t              st1_q;
  logic                s1_vld_q;
  logic                s1_vld_d;
  result_t             res;
  result_t             out_q;
  logic                out_vld_q;
  logic                out_vld_d;
  logic                en1;
  logic                en2;

  function automatic pix_t absdiff(pix_t a, pix_t b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  // Unpack the request
  always_comb begin
    for (int k = 0; k < 10; k++) begin
      smp[k] = s_axis_tdata[8*k +: 8];
    end
    q = s_axis_tdata[87:80];
  end

  // Select pads and build the padded line
  always_comb begin
    pad_l = (absdiff(smp[0], smp[1]) < q) ? smp[0] : smp[1];
    pad_r = (absdiff(smp[8], smp[9]) < q) ? smp[9] : smp[8];
    for (int k = 0; k < 3; k++) begin
      ext[k]      = pad_l;
      ext[11 + k] = pad_r;
    end
    for (int k = 0; k < NumLanes; k++) begin
      ext[3 + k] = smp[1 + k];
    end
  end

  // Filter lanes, one per centre sample
  for (genvar g = 0; g < NumLanes; g++) begin : g_lane
    for (genvar t = 0; t < NumTaps; t++) begin : g_tap
      assign lane_taps[g][t] = ext[g + t];
    end
    dlf_filter_lane u_lane (
      .taps_i (lane_taps[g]),
      .pix_o  (lane_pix[g])
    );
  end

  // Variance lanes, one per half
  dlf_var_lane u_var_l (
    .pix_i ({smp[4], smp[3], smp[2], smp[1]}),
    .sum_o (sum_l),
    .sq_o  (sq_l)
  );

  dlf_var_lane u_var_r (
    .pix_i ({smp[8], smp[7], smp[6], smp[5]}),
    .sum_o (sum_r),
    .sq_o  (sq_r)
  );

  // Gather the stage-one record
  always_comb begin
    st1_d.sum_l     = sum_l;
    st1_d.sum_r     = sum_r;
    st1_d.sq_l      = sq_l;
    st1_d.sq_r      = sq_r;
    st1_d.qq        = q * q;
    st1_d.edge_busy = absdiff(smp[4], smp[5]) >= q;
    st1_d.filt      = lane_pix;
    for (int k = 0; k < NumLanes; k++) begin
      st1_d.raw[k] = smp[1 + k];
    end
  end

  // Merge the lanes behind stage one
  dlf_merge u_merge (
    .st_i  (st1_q),
    .res_o (res)
  );

  // Advance each stage when its successor has room
  always_comb begin
    en2       = !out_vld_q || m_axis_tready;
    en1       = !s1_vld_q || en2;
    s1_vld_d  = en1 ? s_axis_tvalid : s1_vld_q;
    out_vld_d = en2 ? s1_vld_q : out_vld_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      s1_vld_q  <= s1_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && s_axis_tvalid) begin
      st1_q <= st1_d;
    end
    if (en2 && s1_vld_q) begin
      out_q <= res;
    end
  end

  assign s_axis_tready = en1;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {6'b0, out_q.var_sum, out_q.filt};
  assign m_axis_tuser  = out_q.smoothed;

  `include "assert_macros.svh"

  `DLF_ASSERT_NEXT(a_s1_hold, s1_vld_q && !en2, s1_vld_q && $stable(st1_q), "held line lost")
  `DLF_ASSERT_NEXT(a_s1_fill, s_axis_tvalid && s_axis_tready, s1_vld_q, "accepted line lost")
  `DLF_ASSERT(a_zero_q, s1_vld_q && res.smoothed |-> st1_q.qq != 16'd0, "smoothed with zero step")

endmodule
